// File: rtl/lsc_pkg.sv
// Shared types, constants and helper functions for the lane steering controller.
// No dependencies; every other file but lsc_if imports this package.
package lsc_pkg;

	// APB address width: eight 32-bit registers
	localparam int unsigned ADDR_W = 5;

	// Raw Q16.16 code that marks a missing coordinate (1000.0)
	localparam logic signed [31:0] MISSING_RAW = 32'sd65536000;

	// Cone x spread at or below this raw value counts as equal x
	localparam logic signed [31:0] NEAR_X_LIMIT = 32'sd65;

	localparam int unsigned CORDIC_STEPS = 23;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_ONE  = 2'd1,
		MODE_TWO  = 2'd2,
		MODE_VERT = 2'd3
	} path_mode_t;

	typedef enum logic [2:0] {
		REG_KP_HEADING = 3'd0,
		REG_KI_HEADING = 3'd1,
		REG_KD_HEADING = 3'd2,
		REG_KP_LATERAL = 3'd3,
		REG_KI_LATERAL = 3'd4,
		REG_KD_LATERAL = 3'd5,
		REG_CLEAR_BAND = 3'd6,
		REG_SENSOR_OFS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        kp_heading;
		logic [15:0]        ki_heading;
		logic [15:0]        kd_heading;
		logic [15:0]        kp_lateral;
		logic [15:0]        ki_lateral;
		logic [15:0]        kd_lateral;
		logic [30:0]        integral_clear_band;
		logic signed [31:0] sensor_offset;
	} lsc_cfg_t;

	// atan(2^-i) in Q16.16 degrees, rounded
	function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd2949120;
			5'd1:  r = 32'sd1740967;
			5'd2:  r = 32'sd919879;
			5'd3:  r = 32'sd466945;
			5'd4:  r = 32'sd234379;
			5'd5:  r = 32'sd117304;
			5'd6:  r = 32'sd58666;
			5'd7:  r = 32'sd29335;
			5'd8:  r = 32'sd14668;
			5'd9:  r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Clamp to +-(2^31-1)
	function automatic logic signed [31:0] sat31(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh07FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -34'sh07FFFFFFF)
			r = 32'sh80000001;
		else
			r = v[31:0];
		return r;
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sh07FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -65'sh080000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/lsc_if.sv
// Valid/ready channel interfaces for the lane steering controller.
// Input request carries cone and centerline points; output request carries the drives.
interface lsc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_x;
	logic signed [31:0] left_y;
	logic signed [31:0] right_x;
	logic signed [31:0] right_y;
	logic signed [31:0] near_mid_x;
	logic signed [31:0] near_mid_y;
	logic signed [31:0] far_mid_x;
	logic signed [31:0] far_mid_y;

	modport source (output valid, left_x, left_y, right_x, right_y, near_mid_x,
		near_mid_y, far_mid_x, far_mid_y, input ready);
	modport sink (input valid, left_x, left_y, right_x, right_y, near_mid_x,
		near_mid_y, far_mid_x, far_mid_y, output ready);
endinterface

interface lsc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] steer_angle;
	logic [7:0]         steer_byte;
	logic signed [31:0] heading_drive;
	logic signed [31:0] lateral_drive;
	logic [1:0]         path_mode;

	modport source (output valid, steer_angle, steer_byte, heading_drive,
		lateral_drive, path_mode, input ready);
	modport sink (input valid, steer_angle, steer_byte, heading_drive,
		lateral_drive, path_mode, output ready);
endinterface

// File: rtl/lsc_regs.sv
// APB configuration register bank for the lane steering controller.
// Depends on lsc_pkg for the register index codes and the config struct.
module lsc_regs import lsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output lsc_cfg_t          cfg
);

	lsc_cfg_t cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write one register per completed access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_heading          <= 16'd2048;
			cfg_q.ki_heading          <= 16'd0;
			cfg_q.kd_heading          <= 16'd0;
			cfg_q.kp_lateral          <= 16'd22528;
			cfg_q.ki_lateral          <= 16'd0;
			cfg_q.kd_lateral          <= 16'd0;
			cfg_q.integral_clear_band <= 31'd6554;
			cfg_q.sensor_offset       <= 32'sd0;
		end else if (wr_en) begin
			case (idx)
				REG_KP_HEADING: cfg_q.kp_heading <= pwdata[15:0];
				REG_KI_HEADING: cfg_q.ki_heading <= pwdata[15:0];
				REG_KD_HEADING: cfg_q.kd_heading <= pwdata[15:0];
				REG_KP_LATERAL: cfg_q.kp_lateral <= pwdata[15:0];
				REG_KI_LATERAL: cfg_q.ki_lateral <= pwdata[15:0];
				REG_KD_LATERAL: cfg_q.kd_lateral <= pwdata[15:0];
				REG_CLEAR_BAND: cfg_q.integral_clear_band <= pwdata[30:0];
				REG_SENSOR_OFS: cfg_q.sensor_offset <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (idx)
			REG_KP_HEADING: prdata = {16'd0, cfg_q.kp_heading};
			REG_KI_HEADING: prdata = {16'd0, cfg_q.ki_heading};
			REG_KD_HEADING: prdata = {16'd0, cfg_q.kd_heading};
			REG_KP_LATERAL: prdata = {16'd0, cfg_q.kp_lateral};
			REG_KI_LATERAL: prdata = {16'd0, cfg_q.ki_lateral};
			REG_KD_LATERAL: prdata = {16'd0, cfg_q.kd_lateral};
			REG_CLEAR_BAND: prdata = {1'b0, cfg_q.integral_clear_band};
			REG_SENSOR_OFS: prdata = cfg_q.sensor_offset;
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/lane_steering_controller_core.sv
// Lane steering controller top level: sequencer around one shared multiplier,
// a CORDIC shift-add step, a square-root step and a divide step.
// Depends on lsc_pkg, lsc_if (channels) and lsc_regs (APB bank).
//
//  Channel   Dir  Handshake            Contents
//  cones     in   valid/ready          left/right cones, near/far centerline points
//  steer     out  valid/ready          steer_angle, steer_byte, drives, path_mode
//  APB       in   psel/penable/pready  eight gain, band and offset registers
//
// A request with a usable path keeps cones.ready low through the decode, CORDIC,
// multiply, square-root, divide, heading and lateral PID and output steps; the
// single divide/root/CORDIC units work one bit or one step per cycle.
// Requests that run no PID (no path, special one-point cases, vertical line) go from
// decode straight to the output step.
// After reset the block is ready at once; cones.ready is high only when idle.
// A result waiting on a stalled steer channel does not block the next request;
// the sequencer only waits at its final step if the output register is still full.
module lane_steering_controller_core import lsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	lsc_in_if.sink            cones,
	lsc_out_if.source         steer
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DEC  = 8'b0000_0010,
		S_CORD = 8'b0000_0100,
		S_MUL  = 8'b0000_1000,
		S_SQRT = 8'b0001_0000,
		S_DIV  = 8'b0010_0000,
		S_PID  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	lsc_cfg_t cfg;

	lsc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t             state_q;
	logic [5:0]         cnt_q;
	path_mode_t         mode_q;
	logic               pid_sel_q;

	logic signed [31:0] lx_q, ly_q, rx_q, ry_q, m1x_q, m1y_q, m2x_q, m2y_q;
	logic signed [31:0] ux_q, uy_q, ax_q, ay_q;
	logic signed [34:0] cx_q, cy_q;
	logic signed [31:0] z_q;
	logic signed [65:0] mul_q;
	logic signed [63:0] p1_q, cr_q;
	logic [63:0]        num_q, rt_q, bit_q, dvd_q;
	logic [31:0]        rem_q, s_q;
	logic signed [31:0] lat_q;
	logic signed [32:0] err_q;
	logic signed [63:0] acc_q, hi_q, it_q;

	logic signed [47:0] heading_sum_q, lateral_sum_q;
	logic signed [31:0] heading_prev_q, lateral_prev_q;
	logic signed [31:0] held_steer_q, held_hd_q, held_ld_q;

	logic               out_valid_q;
	logic signed [31:0] out_steer_q, out_hd_q, out_ld_q;
	logic [7:0]         out_byte_q;
	path_mode_t         out_mode_q;

	// ---------------- decode of the latched request ----------------
	logic               near_ok, far_gone, far_ok;
	logic signed [31:0] dx, dy, ux2, uy2, axv, ayv;
	logic signed [32:0] cxv;

	always_comb begin
		near_ok  = (m1x_q != MISSING_RAW) && (m1y_q != MISSING_RAW);
		far_gone = (m2x_q == MISSING_RAW) && (m2y_q == MISSING_RAW);
		far_ok   = (m2x_q != MISSING_RAW) && (m2y_q != MISSING_RAW);
		dx  = sat31(34'(lx_q) - 34'(rx_q));
		dy  = sat31(34'(ly_q) - 34'(ry_q));
		ux2 = sat31(34'(m2x_q) - 34'(m1x_q));
		uy2 = sat31(34'(m2y_q) - 34'(m1y_q));
		cxv = -33'(cfg.sensor_offset);
		axv = sat31(34'(cxv) - 34'(m1x_q));
		ayv = sat31(34'sd0 - 34'(m1y_q));
	end

	// ---------------- shared multiplier operand select ----------------
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic [15:0]        kp_g, ki_g, kd_g;
	logic signed [47:0] sum_cur;
	logic signed [31:0] prev_cur;

	always_comb begin
		kp_g     = pid_sel_q ? cfg.kp_lateral : cfg.kp_heading;
		ki_g     = pid_sel_q ? cfg.ki_lateral : cfg.ki_heading;
		kd_g     = pid_sel_q ? cfg.kd_lateral : cfg.kd_heading;
		sum_cur  = pid_sel_q ? lateral_sum_q : heading_sum_q;
		prev_cur = pid_sel_q ? lateral_prev_q : heading_prev_q;
		ma = 33'sd0;
		mb = 33'sd0;
		if (state_q == S_MUL) begin
			case (cnt_q[2:0])
				3'd0:    begin ma = 33'(ux_q); mb = 33'(ay_q); end
				3'd1:    begin ma = 33'(uy_q); mb = 33'(ax_q); end
				3'd2:    begin ma = 33'(ux_q); mb = 33'(ux_q); end
				3'd3:    begin ma = 33'(uy_q); mb = 33'(uy_q); end
				default: begin ma = 33'sd0;    mb = 33'sd0;    end
			endcase
		end else if (state_q == S_PID) begin
			case (cnt_q[2:0])
				3'd0:    begin ma = $signed({17'd0, kp_g}); mb = err_q; end
				3'd1:    begin ma = $signed({17'd0, kd_g}); mb = err_q - 33'(prev_cur); end
				3'd2:    begin
					ma = $signed({17'd0, ki_g});
					mb = 33'($signed(sum_cur[47:24]));
				end
				3'd3:    begin ma = $signed({17'd0, ki_g}); mb = $signed({9'd0, sum_cur[23:0]}); end
				default: begin ma = 33'sd0; mb = 33'sd0; end
			endcase
		end
	end

	assign prod = ma * mb;

	// ---------------- step units ----------------
	logic signed [34:0] xs, ys;
	logic [63:0]        trial, rt_d;
	logic [32:0]        div_sh;
	logic [63:0]        dvd_d;
	logic [30:0]        quo_sat;
	logic signed [31:0] lat_d;
	logic signed [48:0] sum_add;
	logic signed [47:0] sum_new;
	logic [32:0]        err_mag;
	logic signed [64:0] acc_add;
	logic signed [63:0] acc_sat, acc_sh;
	logic signed [31:0] drive_d, steer_d;

	always_comb begin
		// CORDIC shifts
		xs = cx_q >>> cnt_q[4:0];
		ys = cy_q >>> cnt_q[4:0];
		// square-root digit
		trial = rt_q + bit_q;
		rt_d  = (num_q >= trial) ? ((rt_q >> 1) + bit_q) : (rt_q >> 1);
		// restoring divide bit
		div_sh = {rem_q, dvd_q[63]};
		dvd_d  = {dvd_q[62:0], (div_sh >= {1'b0, s_q})};
		quo_sat = (dvd_d[63:31] != 33'd0) ? 31'h7FFFFFFF : dvd_d[30:0];
		if (s_q == 32'd0)
			lat_d = 32'sd0;
		else if (cr_q > 64'sd0)
			lat_d = $signed({1'b0, quo_sat});
		else if (cr_q < 64'sd0)
			lat_d = -$signed({1'b0, quo_sat});
		else
			lat_d = 32'sd0;
		// integral update with clear band
		sum_add = 49'(sum_cur) + 49'(err_q);
		if (sum_add[48] != sum_add[47])
			sum_new = sum_add[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			sum_new = sum_add[47:0];
		err_mag = err_q[32] ? 33'(-err_q) : 33'(err_q);
		if (err_mag < {2'b00, cfg.integral_clear_band})
			sum_new = 48'sd0;
		// saturating 64-bit accumulate of the integral term
		acc_add = 65'(acc_q) + 65'(it_q);
		if (acc_add[64] != acc_add[63])
			acc_sat = acc_add[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			acc_sat = acc_add[63:0];
		acc_sh  = acc_q >>> 8;
		drive_d = sat32(-65'(acc_sh));
		steer_d = sat32(65'(held_hd_q) + 65'(drive_d));
	end

	// steer_byte: integer part truncated toward zero, low 8 bits
	logic [7:0] byte_d;
	assign byte_d = held_steer_q[23:16] +
		8'(held_steer_q[31] && (held_steer_q[15:0] != 16'd0));

	assign cones.ready = (state_q == S_IDLE);

	// ---------------- sequencer and datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= 6'd0;
			mode_q         <= MODE_NONE;
			pid_sel_q      <= 1'b0;
			heading_sum_q  <= 48'sd0;
			lateral_sum_q  <= 48'sd0;
			heading_prev_q <= 32'sd0;
			lateral_prev_q <= 32'sd0;
			held_steer_q   <= 32'sd0;
			held_hd_q      <= 32'sd0;
			held_ld_q      <= 32'sd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// take a request
					if (cones.valid) begin
						lx_q    <= cones.left_x;
						ly_q    <= cones.left_y;
						rx_q    <= cones.right_x;
						ry_q    <= cones.right_y;
						m1x_q   <= cones.near_mid_x;
						m1y_q   <= cones.near_mid_y;
						m2x_q   <= cones.far_mid_x;
						m2y_q   <= cones.far_mid_y;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					ax_q  <= axv;
					ay_q  <= ayv;
					cnt_q <= 6'd0;
					state_q <= S_OUT;
					if (near_ok && far_gone) begin
						mode_q <= MODE_ONE;
						if (dy == 32'sd0) begin
							held_steer_q <= MISSING_RAW;
						end else if (dx <= NEAR_X_LIMIT && dx >= -NEAR_X_LIMIT) begin
							held_steer_q <= 32'sd0;
						end else begin
							// perpendicular to the cone line, toward increasing x
							ux_q <= (dy > 32'sd0) ? dy : -dy;
							uy_q <= (dy > 32'sd0) ? -dx : dx;
							cx_q <= (dy > 32'sd0) ? 35'(dy) : -35'(dy);
							cy_q <= (dy > 32'sd0) ? -35'(dx) : 35'(dx);
							z_q  <= 32'sd0;
							state_q <= S_CORD;
						end
					end else if (near_ok && far_ok) begin
						if (ux2 == 32'sd0) begin
							mode_q <= MODE_VERT;
						end else begin
							mode_q <= MODE_TWO;
							ux_q <= ux2;
							uy_q <= uy2;
							cx_q <= (ux2 < 32'sd0) ? -35'(ux2) : 35'(ux2);
							cy_q <= (ux2 < 32'sd0) ? -35'(uy2) : 35'(uy2);
							z_q  <= 32'sd0;
							state_q <= S_CORD;
						end
					end else begin
						mode_q    <= MODE_NONE;
						held_hd_q <= MISSING_RAW;
						held_ld_q <= MISSING_RAW;
					end
				end
				S_CORD: begin
					// rotate toward the x axis, collect the angle
					if (cy_q > 35'sd0) begin
						cx_q <= cx_q + ys;
						cy_q <= cy_q - xs;
						z_q  <= z_q + atan_deg(cnt_q[4:0]);
					end else begin
						cx_q <= cx_q - ys;
						cy_q <= cy_q + xs;
						z_q  <= z_q - atan_deg(cnt_q[4:0]);
					end
					if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
						cnt_q   <= 6'd0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_MUL: begin
					// cross product and squared length on the shared multiplier
					mul_q <= prod;
					cnt_q <= cnt_q + 6'd1;
					case (cnt_q[2:0])
						3'd1: p1_q  <= mul_q[63:0];
						3'd2: cr_q  <= p1_q - mul_q[63:0];
						3'd3: num_q <= mul_q[63:0];
						3'd4: begin
							num_q   <= num_q + mul_q[63:0];
							rt_q    <= 64'd0;
							bit_q   <= 64'd1 << 62;
							cnt_q   <= 6'd0;
							state_q <= S_SQRT;
						end
						default: ;
					endcase
				end
				S_SQRT: begin
					if (num_q >= trial)
						num_q <= num_q - trial;
					rt_q  <= rt_d;
					bit_q <= bit_q >> 2;
					if (cnt_q == 6'd31) begin
						s_q     <= rt_d[31:0];
						dvd_q   <= cr_q[63] ? 64'(-cr_q) : 64'(cr_q);
						rem_q   <= 32'd0;
						cnt_q   <= 6'd0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_DIV: begin
					rem_q <= (div_sh >= {1'b0, s_q}) ? 32'(div_sh - {1'b0, s_q})
						: div_sh[31:0];
					dvd_q <= dvd_d;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						lat_q     <= lat_d;
						err_q     <= 33'(z_q);
						pid_sel_q <= 1'b0;
						cnt_q     <= 6'd0;
						state_q   <= S_PID;
					end
				end
				S_PID: begin
					mul_q <= prod;
					cnt_q <= cnt_q + 6'd1;
					case (cnt_q[2:0])
						3'd0: begin
							if (pid_sel_q) lateral_sum_q <= sum_new;
							else           heading_sum_q <= sum_new;
						end
						3'd1: begin
							acc_q <= mul_q[63:0];
							if (pid_sel_q) lateral_prev_q <= err_q[31:0];
							else           heading_prev_q <= err_q[31:0];
						end
						3'd2: acc_q <= acc_q + mul_q[63:0];
						3'd3: hi_q  <= mul_q[63:0];
						3'd4: it_q  <= (hi_q <<< 24) + mul_q[63:0];
						3'd5: acc_q <= acc_sat;
						3'd6: begin
							cnt_q <= 6'd0;
							if (!pid_sel_q) begin
								held_hd_q <= drive_d;
								err_q     <= -33'(lat_q);
								pid_sel_q <= 1'b1;
							end else begin
								held_ld_q    <= drive_d;
								held_steer_q <= steer_d;
								state_q      <= S_OUT;
							end
						end
						default: ;
					endcase
				end
				S_OUT: begin
					// hand over once the output register is free
					if (!out_valid_q || steer.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- output register ----------------
	logic out_load;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || steer.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (steer.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_steer_q <= held_steer_q;
			out_byte_q  <= byte_d;
			out_hd_q    <= held_hd_q;
			out_ld_q    <= held_ld_q;
			out_mode_q  <= mode_q;
		end
	end

	assign steer.valid         = out_valid_q;
	assign steer.steer_angle   = out_steer_q;
	assign steer.steer_byte    = out_byte_q;
	assign steer.heading_drive = out_hd_q;
	assign steer.lateral_drive = out_ld_q;
	assign steer.path_mode     = out_mode_q;

	// ---------------- assertions ----------------
	a_accept_to_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(cones.valid && cones.ready) |=> (state_q == S_DEC))
		else $error("accepted request did not enter decode");

	a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> $onehot(bit_q))
		else $error("square-root trial bit lost its single bit");

	a_no_path_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(steer.valid && steer.path_mode == MODE_NONE) |->
		(steer.heading_drive == MISSING_RAW && steer.lateral_drive == MISSING_RAW))
		else $error("no-path result without missing drives");

	a_lateral_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PID) |-> (lat_q != 32'sh80000000))
		else $error("lateral error escaped its saturation range");

endmodule

// File: dv/tb_lane_steering_controller_core.sv
// Testbench for lane_steering_controller_core: random and directed cone requests,
// checked against an in-bench fixed-point predictor. Depends on lsc_pkg and lsc_if.
`timescale 1ns / 1ps

module tb_lane_steering_controller_core;
	import lsc_pkg::*;

	localparam longint MISS      = 65536000;
	localparam longint S31       = 64'sh7FFFFFFF;
	localparam longint SUM_TOP   = 64'sh00007FFFFFFFFFFF;
	localparam longint ACC_TOP   = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint ACC_BOT   = 64'sh8000000000000000;
	localparam int     LIMIT     = 2000000;
	localparam int     SETTLE    = 200;

	typedef struct {
		logic signed [31:0] left_x, left_y, right_x, right_y;
		logic signed [31:0] near_x, near_y, far_x, far_y;
	} cones_t;

	typedef struct {
		logic signed [31:0] steer_angle;
		logic [7:0]         steer_byte;
		logic signed [31:0] heading_drive;
		logic signed [31:0] lateral_drive;
		logic [1:0]         path_mode;
	} steer_t;

	// Predictor and expected-steer store
	class steer_scoreboard;
		longint kp_h, ki_h, kd_h, kp_l, ki_l, kd_l, band, ofs;
		longint h_sum, h_prev, l_sum, l_prev, held_steer, held_hd, held_ld;
		steer_t expected_q[$];
		int     mismatches;
		longint atan_tab[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

		function new();
			kp_h = 2048; ki_h = 0; kd_h = 0;
			kp_l = 22528; ki_l = 0; kd_l = 0;
			band = 6554; ofs = 0;
			h_sum = 0; h_prev = 0; l_sum = 0; l_prev = 0;
			held_steer = 0; held_hd = 0; held_ld = 0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
				REG_KP_HEADING: kp_h = longint'(v[15:0]);
				REG_KI_HEADING: ki_h = longint'(v[15:0]);
				REG_KD_HEADING: kd_h = longint'(v[15:0]);
				REG_KP_LATERAL: kp_l = longint'(v[15:0]);
				REG_KI_LATERAL: ki_l = longint'(v[15:0]);
				REG_KD_LATERAL: kd_l = longint'(v[15:0]);
				REG_CLEAR_BAND: band = longint'(v[30:0]);
				REG_SENSOR_OFS: ofs = longint'($signed(v));
				default: ;
			endcase
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint magn(longint v);
			return v < 0 ? -v : v;
		endfunction

		// Vectoring CORDIC, returns -atan(uy/ux) in Q16.16 degrees
		function longint heading_of(longint ux, longint uy);
			longint x, y, z, xs, ys;
			x = ux < 0 ? -ux : ux;
			y = ux < 0 ? -uy : uy;
			z = 0;
			for (int i = 0; i < 23; i++) begin
				ys = y >>> i;
				xs = x >>> i;
				if (y > 0) begin
					x += ys; y -= xs; z += atan_tab[i];
				end else begin
					x -= ys; y += xs; z -= atan_tab[i];
				end
			end
			return -z;
		endfunction

		// Signed distance from the vehicle centre to the path line
		function longint offset_of(longint ux, longint uy, longint px, longint py);
			longint ax, ay, cr;
			longint unsigned n, r, b, d;
			ax = clip(-ofs - px, -S31, S31);
			ay = clip(-py, -S31, S31);
			cr = ux * ay - uy * ax;
			n = longint'(ux * ux) + longint'(uy * uy);
			r = 0;
			b = 64'h4000000000000000;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			if (r == 0) return 0;
			d = longint'(magn(cr)) / r;
			if (d > S31) d = S31;
			return cr > 0 ? longint'(d) : (cr < 0 ? -longint'(d) : 0);
		endfunction

		function longint pid_step(longint value, longint kp, longint ki, longint kd,
				ref longint sum, ref longint prev);
			longint err, s, acc, it;
			err = -value;
			s = clip(sum + err, -SUM_TOP - 1, SUM_TOP);
			if (magn(err) < band) s = 0;
			sum = s;
			acc = kp * err + kd * (err - prev);
			it = ki * s;
			if (it > 0 && acc > ACC_TOP - it) acc = ACC_TOP;
			else if (it < 0 && acc < ACC_BOT - it) acc = ACC_BOT;
			else acc += it;
			prev = err;
			return clip(-(acc >>> 8), -S31 - 1, S31);
		endfunction

		function void steer_along(longint ux, longint uy, longint px, longint py);
			longint th, lat;
			th = heading_of(ux, uy);
			lat = offset_of(ux, uy, px, py);
			held_hd = pid_step(th, kp_h, ki_h, kd_h, h_sum, h_prev);
			held_ld = pid_step(lat, kp_l, ki_l, kd_l, l_sum, l_prev);
			held_steer = clip(held_hd + held_ld, -S31 - 1, S31);
		endfunction

		// Note an accepted cone request and queue the steer it must produce
		function void note_cones(cones_t c);
			longint dx, dy, ux, uy, px, py;
			bit near_ok, far_gone, far_ok;
			path_mode_t mode;
			steer_t e;
			near_ok  = c.near_x != MISSING_RAW && c.near_y != MISSING_RAW;
			far_gone = c.far_x == MISSING_RAW && c.far_y == MISSING_RAW;
			far_ok   = c.far_x != MISSING_RAW && c.far_y != MISSING_RAW;
			px = longint'(c.near_x);
			py = longint'(c.near_y);
			if (near_ok && far_gone) begin
				mode = MODE_ONE;
				dx = clip(longint'(c.left_x) - longint'(c.right_x), -S31, S31);
				dy = clip(longint'(c.left_y) - longint'(c.right_y), -S31, S31);
				if (dy == 0) held_steer = MISS;
				else if (magn(dx) <= 65) held_steer = 0;
				else if (dy > 0) steer_along(dy, -dx, px, py);
				else steer_along(-dy, dx, px, py);
			end else if (near_ok && far_ok) begin
				ux = clip(longint'(c.far_x) - px, -S31, S31);
				uy = clip(longint'(c.far_y) - py, -S31, S31);
				if (ux == 0) begin
					mode = MODE_VERT;
				end else begin
					mode = MODE_TWO;
					steer_along(ux, uy, px, py);
				end
			end else begin
				mode = MODE_NONE;
				held_hd = MISS;
				held_ld = MISS;
			end
			e.steer_angle   = held_steer[31:0];
			e.steer_byte    = 8'(held_steer / 65536);
			e.heading_drive = held_hd[31:0];
			e.lateral_drive = held_ld[31:0];
			e.path_mode     = mode;
			expected_q = {expected_q, e};
		endfunction

		// Compare one delivered steer with the oldest expectation
		function void check_steer(steer_t a);
			steer_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected steer result, angle %0d", a.steer_angle);
				return;
			end
			e = expected_q.pop_front();
			if (a.steer_angle !== e.steer_angle || a.steer_byte !== e.steer_byte ||
					a.heading_drive !== e.heading_drive ||
					a.lateral_drive !== e.lateral_drive || a.path_mode !== e.path_mode) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"ERROR: steer exp angle %0d byte %0d hd %0d ld %0d mode %0d",
						" / got %0d %0d %0d %0d %0d"},
						e.steer_angle, e.steer_byte, e.heading_drive, e.lateral_drive,
						e.path_mode, a.steer_angle, a.steer_byte, a.heading_drive,
						a.lateral_drive, a.path_mode);
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	lsc_in_if  cones();
	lsc_out_if steer();

	lane_steering_controller_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cones(cones.sink), .steer(steer.source)
	);

	steer_scoreboard sb = new();
	int  send_idle_pct, recv_idle_pct;
	int  accepted;
	int  cycles;
	int  hold_left;
	bit  hold_done;
	cones_t dir_q[$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watch both channels
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && cones.valid && cones.ready) begin
			sb.note_cones('{cones.left_x, cones.left_y, cones.right_x, cones.right_y,
				cones.near_mid_x, cones.near_mid_y, cones.far_mid_x, cones.far_mid_y});
			accepted <= accepted + 1;
		end
		if (arst_n && steer.valid && steer.ready)
			sb.check_steer('{steer.steer_angle, steer.steer_byte, steer.heading_drive,
				steer.lateral_drive, steer.path_mode});
	end

	// Drive steer ready; hold it off once for a long stretch so the block backs up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			steer.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && accepted >= 500) begin
			steer.ready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else begin
			steer.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Timeout
	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("tb_lane_steering_controller_core: FAIL");
			$finish;
		end
	end

	// Append one directed request
	function automatic void add_dir(cones_t c);
		dir_q = {dir_q, c};
	endfunction

	task automatic apb_write(reg_idx_t idx, logic [31:0] v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// Gains go out with random upper bits, which the block must drop
	task automatic load_settings(logic [15:0] kph, logic [15:0] kih, logic [15:0] kdh,
			logic [15:0] kpl, logic [15:0] kil, logic [15:0] kdl,
			logic [30:0] bnd, logic [31:0] sofs);
		apb_write(REG_KP_HEADING, {16'($urandom), kph});
		apb_write(REG_KI_HEADING, {16'($urandom), kih});
		apb_write(REG_KD_HEADING, {16'($urandom), kdh});
		apb_write(REG_KP_LATERAL, {16'($urandom), kpl});
		apb_write(REG_KI_LATERAL, {16'($urandom), kil});
		apb_write(REG_KD_LATERAL, {16'($urandom), kdl});
		apb_write(REG_CLEAR_BAND, {1'($urandom), bnd});
		apb_write(REG_SENSOR_OFS, sofs);
	endtask

	task automatic send_cones(cones_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cones.valid <= 1'b0;
			@(posedge clk);
		end
		cones.valid <= 1'b1;
		cones.left_x <= c.left_x;      cones.left_y <= c.left_y;
		cones.right_x <= c.right_x;    cones.right_y <= c.right_y;
		cones.near_mid_x <= c.near_x;  cones.near_mid_y <= c.near_y;
		cones.far_mid_x <= c.far_x;    cones.far_mid_y <= c.far_y;
		@(posedge clk);
		while (!cones.ready) @(posedge clk);
	endtask

	// Wait out all pending steers and the block's own latency
	task automatic drain();
		cones.valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [31:0] coord();
		case ($urandom_range(9))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			2: return MISSING_RAW;
			default: return $signed($urandom_range(2621440)) - 32'sd1310720;
		endcase
	endfunction

	function automatic cones_t random_cones();
		cones_t c;
		int kind;
		c = '{coord(), coord(), coord(), coord(), coord(), coord(), coord(), coord()};
		if (c.near_x == MISSING_RAW) c.near_x = 0;
		if (c.near_y == MISSING_RAW) c.near_y = 0;
		kind = $urandom_range(99);
		if (kind < 45) begin
			if (c.far_x == MISSING_RAW) c.far_x = 1;
			if (c.far_y == MISSING_RAW) c.far_y = 1;
		end else if (kind < 80) begin
			c.far_x = MISSING_RAW; c.far_y = MISSING_RAW;
		end else if (kind < 85) begin
			c.far_x = c.near_x;
			if (c.far_y == MISSING_RAW) c.far_y = 1;
		end else if (kind < 90) begin
			c.far_x = MISSING_RAW; c.far_y = MISSING_RAW; c.right_y = c.left_y;
		end else if (kind < 93) begin
			c.far_x = MISSING_RAW; c.far_y = MISSING_RAW;
			c.right_x = c.left_x + $signed($urandom_range(130)) - 32'sd65;
			if (c.right_y == c.left_y) c.right_y = c.left_y + 1;
		end else begin
			case ($urandom_range(3))
				0: c.near_x = MISSING_RAW;
				1: c.near_y = MISSING_RAW;
				2: c.far_x = MISSING_RAW;
				default: begin
					c.near_x = MISSING_RAW; c.near_y = MISSING_RAW; c.far_y = MISSING_RAW;
				end
			endcase
		end
		return c;
	endfunction

	initial begin
		clk = 1'b0; arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		cones.valid = 1'b0;
		cones.left_x = '0; cones.left_y = '0; cones.right_x = '0; cones.right_y = '0;
		cones.near_mid_x = '0; cones.near_mid_y = '0;
		cones.far_mid_x = '0; cones.far_mid_y = '0;
		steer.ready = 1'b0;
		send_idle_pct = 12; recv_idle_pct = 77;
		accepted = 0; cycles = 0; hold_left = 0; hold_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under reset settings
		add_dir('{-65536, 65536, 65536, 65536, 131072, 0, 655360, 131072});
		add_dir('{65536, 0, -65536, 131072, 65536, 65536, MISSING_RAW, MISSING_RAW});
		add_dir('{65536, 131072, -65536, 0, 65536, 65536, MISSING_RAW, MISSING_RAW});
		add_dir('{65536, 65536, -65536, 65536, 0, 0, MISSING_RAW, MISSING_RAW});
		add_dir('{65, 65536, 0, 0, 0, 0, MISSING_RAW, MISSING_RAW});
		add_dir('{-65, 65536, 0, 0, 0, 0, MISSING_RAW, MISSING_RAW});
		add_dir('{66, 65536, 0, 0, 0, 0, MISSING_RAW, MISSING_RAW});
		add_dir('{0, 0, 0, 0, 65536, 0, 65536, 655360});
		add_dir('{0, 0, 0, 0, 0, 0, 0, 0});
		add_dir('{0, 0, 0, 0, MISSING_RAW, MISSING_RAW, MISSING_RAW, MISSING_RAW});
		add_dir('{0, 0, 0, 0, MISSING_RAW, 0, 65536, 65536});
		add_dir('{0, 0, 0, 0, 0, 0, MISSING_RAW, 65536});
		add_dir('{0, 0, 0, 0, 0, MISSING_RAW, MISSING_RAW, MISSING_RAW});
		add_dir('{0, 0, 0, 0, -655360, 0, 655360, 0});
		add_dir('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000});
		add_dir('{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh80000000, MISSING_RAW, MISSING_RAW});
		add_dir('{32'sh80000000, 0, 32'sh7FFFFFFF, 0, 0, 0, MISSING_RAW, MISSING_RAW});
		add_dir('{-1, -1, -1, -1, -1, -1, 32'sh7FFFFFFF, -1});
		add_dir('{0, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000001, 0});
		foreach (dir_q[i]) send_cones(dir_q[i]);
		drain();

		// Random phases, each under its own register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: load_settings(16'd2048, 16'd0, 16'd0, 16'd22528, 16'd0, 16'd0,
					31'd6554, 32'd0);
				1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					31'd0, 32'sh80000000);
				2: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
					31'h7FFFFFFF, 32'sh7FFFFFFF);
				3: load_settings(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom),
					31'($urandom_range(131072)),
					$signed($urandom_range(262144)) - 32'sd131072);
				4: load_settings(16'($urandom), 16'($urandom_range(300)), 16'($urandom),
					16'($urandom), 16'($urandom_range(300)), 16'($urandom),
					31'($urandom), $urandom);
				default: load_settings(16'd512, 16'd64, 16'd256, 16'd4096, 16'd32, 16'd128,
					31'd65536, -32'sd65536);
			endcase
			case (phase / 2)
				0: begin send_idle_pct = 12; recv_idle_pct = 77; end
				1: begin send_idle_pct = 77; recv_idle_pct = 12; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			repeat (180) send_cones(random_cones());
			drain();
		end

		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("tb_lane_steering_controller_core: PASS");
		else
			$display("tb_lane_steering_controller_core: FAIL");
		$finish;
	end

endmodule
